// ----- rtl/ordered_set_table_assert.svh -----
// Assertion macros for the ordered set table top level.
`ifndef ORDERED_SET_TABLE_ASSERT_SVH
`define ORDERED_SET_TABLE_ASSERT_SVH

// Same-cycle implication, disabled while reset is asserted.
`define OST_ASSERT_IMP(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled while reset is asserted.
`define OST_ASSERT_NXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ----- rtl/ost_pkg.sv -----
// Package for the ordered set table: field widths, command codes, cell control.
package ost_pkg;

    localparam int CAPACITY_DEF = 64;
    localparam int CMD_W        = 2;
    localparam int ELEM_W       = 32;
    localparam int COUNT_W      = 7;

    localparam logic [CMD_W-1:0] CMD_INSERT = 2'd0;
    localparam logic [CMD_W-1:0] CMD_REMOVE = 2'd1;
    localparam logic [CMD_W-1:0] CMD_QUERY  = 2'd2;

    typedef struct packed {
        logic load;   // write the transaction value into the cell at the tail
        logic shift;  // close the gap left by a removed entry
    } t_cell_ctl;

endpackage

// ----- rtl/ost_pfx.sv -----
// Pipelined prefix-OR over the cell match flags, one doubling step per stage.
module ost_pfx
    import ost_pkg::*;
#(
    parameter int N = CAPACITY_DEF
) (
    input  logic         i_clk,
    input  logic [N-1:0] i_bits,
    output logic [N-1:0] o_bits
);

    localparam int L = $clog2(N);

    logic [N-1:0] w_lvl [0:L];
    logic [N-1:0] r_stg [0:L-1];

    assign w_lvl[0] = i_bits;

    for (genvar k = 0; k < L; k++) begin : g_stage
        always_ff @(posedge i_clk) begin
            r_stg[k] <= w_lvl[k] | (w_lvl[k] << (1 << k));
        end
        assign w_lvl[k+1] = r_stg[k];
    end

    assign o_bits = w_lvl[L];

endmodule

// ----- rtl/ost_cell.sv -----
// One table cell: holds a value, flags a match, loads or takes its neighbor's value.
module ost_cell
    import ost_pkg::*;
#(
    parameter int IDX   = 0,
    parameter int CNT_W = 7
) (
    input  logic                     i_clk,
    input  t_cell_ctl                i_ctl,
    input  logic        [CNT_W-1:0]  i_occ,
    input  logic signed [ELEM_W-1:0] i_elem,
    input  logic signed [ELEM_W-1:0] i_next,
    input  logic                     i_pref,
    output logic signed [ELEM_W-1:0] o_value,
    output logic                     o_hit
);

    logic signed [ELEM_W-1:0] r_value;
    logic                     r_hit;

    always_ff @(posedge i_clk) begin
        // only cells below the occupancy take part in the lookup
        r_hit <= (r_value == i_elem) && (CNT_W'(IDX) < i_occ);
        if (i_ctl.load && (i_occ == CNT_W'(IDX))) begin
            r_value <= i_elem;
        end else if (i_ctl.shift && i_pref) begin
            r_value <= i_next;
        end
    end

    assign o_value = r_value;
    assign o_hit   = r_hit;

endmodule

// ----- rtl/ordered_set_table.sv -----
// Ordered set table top level: command sequencer, occupancy and a row of cells.
// The result is registered at commit, after the prefix-OR pipeline locates the matching cell.
// One transaction at a time: o_stall holds off new commands until the sequencer is idle,
// and the commit waits while the result output is stalled.
// Reset: synchronous, active low; clears sequencer, occupancy and output valid.
// Cell contents are not cleared; cells at or above the occupancy take no part in the lookup.
`include "ordered_set_table_assert.svh"

module ordered_set_table
    import ost_pkg::*;
#(
    parameter int CAPACITY = CAPACITY_DEF
) (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_valid,
    output logic                      o_stall,
    input  logic        [CMD_W-1:0]   i_cmd,
    input  logic signed [ELEM_W-1:0]  i_element,
    output logic                      o_valid,
    input  logic                      i_stall,
    output logic                      o_ok,
    output logic        [COUNT_W-1:0] o_count
);

    localparam int CNT_W = $clog2(CAPACITY + 1);
    localparam int L     = $clog2(CAPACITY);
    localparam int SCW   = (L > 1) ? $clog2(L) : 1;

    typedef enum logic [3:0] {
        ST_IDLE   = 4'b0001,
        ST_MATCH  = 4'b0010,
        ST_SCAN   = 4'b0100,
        ST_COMMIT = 4'b1000
    } t_state;

    t_state                   r_state, n_state;
    logic        [SCW-1:0]    r_scan,  n_scan;
    logic        [CNT_W-1:0]  r_occ,   n_occ;
    logic        [CMD_W-1:0]  r_cmd;
    logic signed [ELEM_W-1:0] r_elem;
    logic                     r_out_valid;
    logic                     r_ok;
    logic        [COUNT_W-1:0] r_count;

    logic                     n_ok;
    logic                     w_commit;
    logic                     w_out_free;
    logic                     w_present;
    logic                     w_full;
    t_cell_ctl                w_ctl;
    logic        [CAPACITY-1:0] w_hit;
    logic        [CAPACITY-1:0] w_pref;
    logic signed [ELEM_W-1:0] w_value [0:CAPACITY-1];

    for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
        logic signed [ELEM_W-1:0] w_next;
        if (i == CAPACITY - 1) begin : g_last
            assign w_next = w_value[i];
        end else begin : g_mid
            assign w_next = w_value[i+1];
        end
        ost_cell #(
            .IDX   (i),
            .CNT_W (CNT_W)
        ) u_cell (
            .i_clk   (i_clk),
            .i_ctl   (w_ctl),
            .i_occ   (r_occ),
            .i_elem  (r_elem),
            .i_next  (w_next),
            .i_pref  (w_pref[i]),
            .o_value (w_value[i]),
            .o_hit   (w_hit[i])
        );
    end

    ost_pfx #(
        .N (CAPACITY)
    ) u_pfx (
        .i_clk  (i_clk),
        .i_bits (w_hit),
        .o_bits (w_pref)
    );

    assign w_present  = w_pref[CAPACITY-1];
    assign w_full     = (r_occ == CNT_W'(CAPACITY));
    assign w_out_free = !r_out_valid || !i_stall;

    always_comb begin
        n_state  = r_state;
        n_scan   = r_scan;
        n_occ    = r_occ;
        n_ok     = 1'b0;
        w_commit = 1'b0;
        w_ctl    = '0;
        case (r_state)
            ST_IDLE: begin
                if (i_valid) begin
                    n_state = ST_MATCH;
                end
            end
            ST_MATCH: begin
                n_scan  = SCW'(L - 1);
                n_state = ST_SCAN;
            end
            ST_SCAN: begin
                if (r_scan == '0) begin
                    n_state = ST_COMMIT;
                end else begin
                    n_scan = r_scan - 1'b1;
                end
            end
            ST_COMMIT: begin
                if (w_out_free) begin
                    w_commit = 1'b1;
                    n_state  = ST_IDLE;
                    case (r_cmd)
                        CMD_INSERT: begin
                            if (!w_present && !w_full) begin
                                w_ctl.load = 1'b1;
                                n_occ      = r_occ + 1'b1;
                                n_ok       = 1'b1;
                            end
                        end
                        CMD_REMOVE: begin
                            if (w_present) begin
                                w_ctl.shift = 1'b1;
                                n_occ       = r_occ - 1'b1;
                                n_ok        = 1'b1;
                            end
                        end
                        CMD_QUERY: begin
                            n_ok = w_present;
                        end
                        default: begin
                            n_ok = 1'b0;
                        end
                    endcase
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_scan      <= '0;
            r_occ       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            r_scan  <= n_scan;
            r_occ   <= n_occ;
            if (w_commit) begin
                r_out_valid <= 1'b1;
            end else if (!i_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if ((r_state == ST_IDLE) && i_valid) begin
            r_cmd  <= i_cmd;
            r_elem <= i_element;
        end
        if (w_commit) begin
            r_ok    <= n_ok;
            r_count <= COUNT_W'(n_occ);
        end
    end

    assign o_stall = (r_state != ST_IDLE);
    assign o_valid = r_out_valid;
    assign o_ok    = r_ok;
    assign o_count = r_count;

    `OST_ASSERT_IMP(a_occ_bound, i_clk, i_rst_n, 1'b1, r_occ <= CNT_W'(CAPACITY), "occupancy above capacity")
    `OST_ASSERT_IMP(a_single_hit, i_clk, i_rst_n, r_state == ST_SCAN, $onehot0(w_hit), "value held in more than one cell")
    `OST_ASSERT_NXT(a_ins_count, i_clk, i_rst_n, w_commit && w_ctl.load, r_occ == $past(r_occ) + 1'b1, "insert did not grow occupancy")
    `OST_ASSERT_IMP(a_out_src, i_clk, i_rst_n, $rose(o_valid), $past(r_state == ST_COMMIT), "result raised outside commit")

endmodule
